### hdl/rtkrb_pkg.sv
// Shared types and constants for the reward top-k replay buffer.
// No dependencies; used by reward_topk_replay_buffer_core.
package rtkrb_pkg;
	localparam int REWARD_W  = 32;
	localparam int TAG_W     = 16;
	localparam int BATCH_W   = 7;
	localparam int CAP_W     = 11;
	localparam int WEIGHT_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd1;

	localparam logic [CAP_W-1:0]    CAP_RESET    = 11'd1024;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

	typedef struct packed {
		logic [REWARD_W-1:0] reward;
		logic [TAG_W-1:0]    tag;
	} entry_t;
endpackage

### hdl/reward_topk_replay_buffer_core.sv
// Reward top-k replay buffer: ring store, selection-sort sampler, strided sampler.
// Depends on rtkrb_pkg (entry type, command, status and register codes).
//
// channel | signals                                          | notes
// in      | in_valid/in_ready, cmd, entry_reward, entry_tag,  | one request, held by sender
//         | batch_len                                        |
// out     | out_valid/out_ready, status, out_tag, out_reward, | 1..MAX_BATCH results,
//         | last                                             | last marks final one
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data          | always ready
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Add: the shared restoring divider wraps the write position.
// Sort sample (fill <= SORT_LIMIT): copy the store into the order list, then
//   one selection scan per result i, one list entry compared per cycle.
// Strided sample: the divider forms the stride fill/batch, then each result is
//   scaled on the shared 32x32 multiplier. A stalled output holds the sequencer.
// Reset clears control state only; the store holds garbage until written.
module reward_topk_replay_buffer_core #(
	parameter int STORE_DEPTH = 1024,
	parameter int SORT_LIMIT  = 256,
	parameter int MAX_BATCH   = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [rtkrb_pkg::REWARD_W-1:0]     entry_reward,
	input  logic [rtkrb_pkg::TAG_W-1:0]        entry_tag,
	input  logic [rtkrb_pkg::BATCH_W-1:0]      batch_len,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               status,
	output logic [rtkrb_pkg::TAG_W-1:0]        out_tag,
	output logic [rtkrb_pkg::REWARD_W-1:0]     out_reward,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rtkrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtkrb_pkg::CFG_DAT_W-1:0]    cfg_data
);
	localparam int SW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW  = $clog2(STORE_DEPTH + 1);
	localparam int LW  = (SORT_LIMIT > 1) ? $clog2(SORT_LIMIT) : 1;
	localparam int LJW = $clog2(SORT_LIMIT + 1);
	localparam int DCW = $clog2(CW + 1);
	localparam int BW  = rtkrb_pkg::BATCH_W;
	localparam int RW  = rtkrb_pkg::REWARD_W;
	localparam int TW  = rtkrb_pkg::TAG_W;
	localparam int WW  = rtkrb_pkg::WEIGHT_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DIV     = 4'd1;
	localparam logic [3:0] S_ADDOUT  = 4'd2;
	localparam logic [3:0] S_ERR     = 4'd3;
	localparam logic [3:0] S_INIT    = 4'd4;
	localparam logic [3:0] S_SCAN    = 4'd5;
	localparam logic [3:0] S_SWAP    = 4'd6;
	localparam logic [3:0] S_SORTOUT = 4'd7;
	localparam logic [3:0] S_SRD     = 4'd8;
	localparam logic [3:0] S_SM0     = 4'd9;
	localparam logic [3:0] S_SM1     = 4'd10;
	localparam logic [3:0] S_SM2     = 4'd11;
	localparam logic [3:0] S_SM3     = 4'd12;
	localparam logic [3:0] S_SOUT    = 4'd13;

	rtkrb_pkg::entry_t store_mem [STORE_DEPTH];
	rtkrb_pkg::entry_t list_mem [SORT_LIMIT];

	logic [3:0]                  state_q;
	logic [rtkrb_pkg::CAP_W-1:0] cap_reg_q;
	logic [WW-1:0]               weight_q;
	logic [SW-1:0]               slot_q;
	logic [CW-1:0]               fill_q;
	logic                        cmd_q;
	logic [BW-1:0]               b_q;
	logic [BW-1:0]               i_q;
	logic [LJW-1:0]              j_q;
	logic                        rvld_q;
	logic [LJW-1:0]              rpos_q;
	rtkrb_pkg::entry_t           st_rd_q;
	rtkrb_pkg::entry_t           list_rd_q;
	rtkrb_pkg::entry_t           best_q;
	rtkrb_pkg::entry_t           ival_q;
	logic [LJW-1:0]              bpos_q;
	logic [CW-1:0]               step_q;
	logic [CW-1:0]               addr_q;
	logic [CW-1:0]               dv_rem_q;
	logic [CW-1:0]               dv_quo_q;
	logic [CW-1:0]               dv_den_q;
	logic [DCW-1:0]              dv_cnt_q;
	logic [63:0]                 p_q;
	logic [63:0]                 lo_q;
	logic [31:0]                 rm_q;
	logic                        rneg_q;
	logic                        wrneg_q;
	logic                        neg_q;
	logic [47:0]                 tm_q;
	logic [TW-1:0]               tag_q;
	logic                        out_valid_q;
	logic                        status_q;
	logic [TW-1:0]               out_tag_q;
	logic [RW-1:0]               out_reward_q;
	logic                        last_q;

	// clamped ring size
	logic [31:0] cap32;
	logic [CW-1:0] cap;
	always_comb begin
		if (cap_reg_q == '0) cap32 = 32'd1;
		else if ({21'b0, cap_reg_q} > 32'(STORE_DEPTH)) cap32 = 32'(STORE_DEPTH);
		else cap32 = {21'b0, cap_reg_q};
		cap = CW'(cap32);
	end

	// batch clamped to MAX_BATCH, then to the fill
	logic [31:0] b_max;
	logic [31:0] b_clamp;
	always_comb begin
		b_max = ({25'b0, batch_len} > 32'(MAX_BATCH)) ? 32'(MAX_BATCH) : {25'b0, batch_len};
		b_clamp = (b_max > 32'(fill_q)) ? 32'(fill_q) : b_max;
	end

	// ordering: sign of (256 + w) decides direction, zero means all tie
	logic [WW:0] k_fac;
	logic        k_neg;
	logic        k_zero;
	logic        better;
	always_comb begin
		k_fac  = {weight_q[WW-1], weight_q} + (WW+1)'(256);
		k_neg  = k_fac[WW];
		k_zero = (k_fac == '0);
		if (k_zero) better = 1'b0;
		else if (k_neg) better = $signed(list_rd_q.reward) < $signed(best_q.reward);
		else better = $signed(list_rd_q.reward) > $signed(best_q.reward);
	end

	// shared restoring divider step
	logic [CW:0]   dv_trial;
	logic          dv_ge;
	logic [CW:0]   dv_diff;
	logic [CW-1:0] dv_rem_nx;
	logic [CW-1:0] dv_quo_nx;
	always_comb begin
		dv_trial  = {dv_rem_q, dv_quo_q[CW-1]};
		dv_ge     = dv_trial >= {1'b0, dv_den_q};
		dv_diff   = dv_trial - {1'b0, dv_den_q};
		dv_rem_nx = dv_ge ? dv_diff[CW-1:0] : dv_trial[CW-1:0];
		dv_quo_nx = {dv_quo_q[CW-2:0], dv_ge};
	end

	// shared multiplier
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [31:0] r_mag;
	logic [WW-1:0] w_mag;
	always_comb begin
		r_mag = st_rd_q.reward[RW-1] ? (32'd0 - st_rd_q.reward) : st_rd_q.reward;
		w_mag = weight_q[WW-1] ? (WW'(0) - weight_q) : weight_q;
		unique case (state_q)
			S_SM0: begin
				mul_a = {16'b0, w_mag};
				mul_b = r_mag;
			end
			S_SM2: begin
				mul_a = rm_q;
				mul_b = tm_q[31:0];
			end
			default: begin
				mul_a = rm_q;
				mul_b = {16'b0, tm_q[47:32]};
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	logic signed [48:0] t_val;
	always_comb begin
		t_val = 49'sd16777216 + (wrneg_q ? -$signed({1'b0, p_q[47:0]})
		                                 : $signed({1'b0, p_q[47:0]}));
	end

	logic [63:0] q_val;
	logic [RW-1:0] sres;
	always_comb begin
		q_val = (p_q << 8) + (lo_q >> 24);
		if (neg_q) sres = (q_val >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q_val[31:0]);
		else sres = (q_val > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_val[31:0];
	end

	logic out_free;
	logic out_set;
	logic in_acc;
	assign out_free = !out_valid_q || out_ready;
	assign out_set  = out_free && ((state_q == S_ADDOUT) || (state_q == S_ERR) ||
	                               (state_q == S_SORTOUT) || (state_q == S_SOUT));
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// memory ports
	logic [SW-1:0]     st_raddr;
	logic [LW-1:0]     list_raddr;
	logic              list_we;
	logic [LW-1:0]     list_waddr;
	rtkrb_pkg::entry_t list_wdata;
	always_comb begin
		st_raddr   = (state_q == S_INIT) ? SW'(j_q) : SW'(addr_q);
		list_raddr = LW'(j_q);
		list_we    = ((state_q == S_INIT) && rvld_q) ||
		             ((state_q == S_SWAP) && (bpos_q != LJW'(i_q)));
		list_waddr = (state_q == S_INIT) ? LW'(rpos_q) : LW'(bpos_q);
		list_wdata = (state_q == S_INIT) ? st_rd_q : ival_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc && (cmd == rtkrb_pkg::CMD_ADD)) begin
			store_mem[slot_q] <= '{reward: entry_reward, tag: entry_tag};
		end
		st_rd_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		list_rd_q <= list_mem[list_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cap_reg_q    <= rtkrb_pkg::CAP_RESET;
			weight_q     <= rtkrb_pkg::WEIGHT_RESET;
			slot_q       <= '0;
			fill_q       <= '0;
			cmd_q        <= rtkrb_pkg::CMD_ADD;
			b_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			rvld_q       <= 1'b0;
			rpos_q       <= '0;
			best_q       <= '0;
			ival_q       <= '0;
			bpos_q       <= '0;
			step_q       <= '0;
			addr_q       <= '0;
			dv_rem_q     <= '0;
			dv_quo_q     <= '0;
			dv_den_q     <= '0;
			dv_cnt_q     <= '0;
			p_q          <= '0;
			lo_q         <= '0;
			rm_q         <= '0;
			rneg_q       <= 1'b0;
			wrneg_q      <= 1'b0;
			neg_q        <= 1'b0;
			tm_q         <= '0;
			tag_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= rtkrb_pkg::STATUS_OK;
			out_tag_q    <= '0;
			out_reward_q <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_set) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (cfg_valid) begin
				if (cfg_index == rtkrb_pkg::REG_CAPACITY)
					cap_reg_q <= cfg_data[rtkrb_pkg::CAP_W-1:0];
				else if (cfg_index == rtkrb_pkg::REG_WEIGHT)
					weight_q <= cfg_data;
			end

			unique case (state_q) inside
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= cmd;
						if (cmd == rtkrb_pkg::CMD_ADD) begin
							dv_rem_q <= '0;
							dv_quo_q <= CW'(slot_q) + CW'(1);
							dv_den_q <= cap;
							dv_cnt_q <= '0;
							state_q  <= S_DIV;
						end else if (fill_q == '0 || batch_len == '0) begin
							state_q <= S_ERR;
						end else begin
							b_q <= BW'(b_clamp);
							i_q <= '0;
							if (32'(fill_q) > 32'(SORT_LIMIT)) begin
								dv_rem_q <= '0;
								dv_quo_q <= fill_q;
								dv_den_q <= CW'(b_clamp);
								dv_cnt_q <= '0;
								state_q  <= S_DIV;
							end else begin
								j_q     <= '0;
								rvld_q  <= 1'b0;
								state_q <= S_INIT;
							end
						end
					end
				end
				S_DIV: begin
					dv_rem_q <= dv_rem_nx;
					dv_quo_q <= dv_quo_nx;
					dv_cnt_q <= dv_cnt_q + DCW'(1);
					if (dv_cnt_q == DCW'(CW - 1)) begin
						if (cmd_q == rtkrb_pkg::CMD_ADD) begin
							slot_q <= SW'(dv_rem_nx);
							if (fill_q < cap) fill_q <= fill_q + CW'(1);
							state_q <= S_ADDOUT;
						end else begin
							step_q  <= dv_quo_nx;
							addr_q  <= '0;
							state_q <= S_SRD;
						end
					end
				end
				S_ADDOUT, S_ERR: begin
					if (out_free) begin
						status_q     <= (state_q == S_ERR) ? rtkrb_pkg::STATUS_INVALID
						                                   : rtkrb_pkg::STATUS_OK;
						out_tag_q    <= '0;
						out_reward_q <= '0;
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_INIT: begin
					// copy store[0..n-1] into the order list, one entry a cycle
					if (32'(j_q) < 32'(fill_q)) begin
						j_q    <= j_q + LJW'(1);
						rvld_q <= 1'b1;
						rpos_q <= j_q;
					end else begin
						rvld_q <= 1'b0;
						if (!rvld_q) begin
							j_q     <= LJW'(i_q);
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (32'(j_q) < 32'(fill_q)) begin
						j_q    <= j_q + LJW'(1);
						rvld_q <= 1'b1;
						rpos_q <= j_q;
					end else begin
						rvld_q <= 1'b0;
					end
					if (rvld_q) begin
						if (rpos_q == LJW'(i_q)) begin
							best_q <= list_rd_q;
							ival_q <= list_rd_q;
							bpos_q <= rpos_q;
						end else if (better) begin
							best_q <= list_rd_q;
							bpos_q <= rpos_q;
						end
					end else if (32'(j_q) >= 32'(fill_q)) begin
						state_q <= S_SWAP;
					end
				end
				S_SWAP: begin
					// position i is final; only the chosen slot takes the old entry
					state_q <= S_SORTOUT;
				end
				S_SORTOUT: begin
					if (out_free) begin
						status_q     <= rtkrb_pkg::STATUS_OK;
						out_tag_q    <= best_q.tag;
						out_reward_q <= best_q.reward;
						last_q       <= (i_q + BW'(1) == b_q);
						if (i_q + BW'(1) == b_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + BW'(1);
							j_q     <= LJW'(i_q + BW'(1));
							rvld_q  <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SRD: begin
					state_q <= S_SM0;
				end
				S_SM0: begin
					p_q     <= mul_p;
					rm_q    <= r_mag;
					rneg_q  <= st_rd_q.reward[RW-1];
					wrneg_q <= st_rd_q.reward[RW-1] ^ weight_q[WW-1];
					tag_q   <= st_rd_q.tag;
					state_q <= S_SM1;
				end
				S_SM1: begin
					tm_q    <= t_val[48] ? 48'(-t_val) : 48'(t_val);
					neg_q   <= rneg_q ^ t_val[48];
					state_q <= S_SM2;
				end
				S_SM2: begin
					lo_q    <= mul_p;
					state_q <= S_SM3;
				end
				S_SM3: begin
					p_q     <= mul_p;
					state_q <= S_SOUT;
				end
				S_SOUT: begin
					if (out_free) begin
						status_q     <= rtkrb_pkg::STATUS_OK;
						out_tag_q    <= tag_q;
						out_reward_q <= sres;
						last_q       <= (i_q + BW'(1) == b_q);
						if (i_q + BW'(1) == b_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + BW'(1);
							addr_q  <= addr_q + step_q;
							state_q <= S_SRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_tag    = out_tag_q;
	assign out_reward = out_reward_q;
	assign last       = last_q;
endmodule
